@@ rtl/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Next-fit slot allocator package
// Pool geometry, occupancy word layout, operation codes and the finder result type.
// ----------------------------------------------------------------------------
package nfsa_pkg;

   localparam int POOL_SLOTS = 4096;
   localparam int FIELD_W    = 12;
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ROWS       = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W     = ROW_W + BIT_W;
   localparam int VISIT_W    = $clog2(ROWS + 1);
   localparam int LAST_BITS  = POOL_SLOTS - (ROWS - 1) * WORD_BITS;

   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [BIT_W-1:0]     bit_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [VISIT_W-1:0]   visit_type;

   typedef struct packed {
      logic    found;
      bit_type index;
   } find_type;

endpackage

@@ rtl/nfsa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nfsa_find.sv @@
// ----------------------------------------------------------------------------
// Next-fit slot allocator free-bit finder
// Lowest free slot of one occupancy word inside a search window.
// ----------------------------------------------------------------------------
module nfsa_find import nfsa_pkg::*; (
   input  word_type occupied,
   input  word_type window,
   output find_type result
);

   word_type free_bits;

   assign free_bits = ~occupied & window;

   always_comb begin
      result = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            result.found = 1'b1;
            result.index = bit_type'(i);
         end
      end
   end

endmodule

@@ rtl/next_fit_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// Next-fit slot allocator
// Free item: ST_FREE clears the bit of an in-pool slot, then ST_RESP registers the response.
// Allocate item: ST_SCAN searches 1 to ROWS + 1 rows, one 64-slot row per cycle
//   through the finder, then ST_RESP registers the response.
// One item at a time; the next item is taken while a result waits to transfer, and
//   a new result holds until the waiting one transfers.
// Reset clears the pointer and the per-row valid bits, so the map
//   reads as all free at once.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator import nfsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] slot_to_free, [15:12] zero
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] granted_slot, [15:12] zero
   output logic        rsp_tuser    // [0] alloc_failed
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   slot_type             ptr_ff, ptr_in;
   row_type              row_ff, row_in;
   bit_type              bit_ff, bit_in;
   visit_type            visit_ff, visit_in;
   logic                 victim_ok_ff, victim_ok_in;
   logic [FIELD_W-1:0]   slot_ff, slot_in;
   logic                 fail_ff, fail_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                 rsp_fail_ff, rsp_fail_in;
   logic [ROWS-1:0]      row_valid_ff, row_valid_in;

   logic                 req_xfer;
   logic [31:0]          victim_ext;
   slot_type             victim_slot;
   row_type              ptr_row;
   bit_type              ptr_bit;
   row_type              row_next;
   word_type             ram_rd;
   word_type             rd_word;
   word_type             ge_mask;
   word_type             scan_mask;
   find_type             hit;
   slot_type             hit_slot;
   logic [31:0]          hit_ext;
   logic [31:0]          ptr_sum;
   logic                 wr_en;
   word_type             wr_data;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign victim_ext  = 32'(req_tdata[FIELD_W-1:0]);
   assign victim_slot = victim_ext[SLOT_W-1:0];
   assign ptr_row     = ptr_ff[SLOT_W-1:BIT_W];
   assign ptr_bit     = ptr_ff[BIT_W-1:0];
   assign row_next    = (row_ff == row_type'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign rd_word     = row_valid_ff[row_ff] ? ram_rd : '0;
   assign ge_mask     = {WORD_BITS{1'b1}} << ptr_bit;
   assign hit_slot    = {row_ff, hit.index};
   assign hit_ext     = 32'(hit_slot);
   assign ptr_sum     = hit_ext + 32'd1;

   always_comb begin
      scan_mask = '1;
      if (visit_ff == '0) begin
         scan_mask = ge_mask;
      end else if (visit_ff == visit_type'(ROWS)) begin
         scan_mask = ~ge_mask;
      end
      if (row_ff == row_type'(ROWS - 1)) begin
         scan_mask = scan_mask & LAST_MASK;
      end
   end

   nfsa_find u_find (
      .occupied (rd_word),
      .window   (scan_mask),
      .result   (hit)
   );

   nfsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_addr (row_in),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      visit_in     = visit_ff;
      victim_ok_in = victim_ok_ff;
      slot_in      = slot_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fail_in  = rsp_fail_ff;
      row_valid_in = row_valid_ff;
      wr_en        = 1'b0;
      wr_data      = rd_word;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               visit_in = '0;
               slot_in  = '0;
               fail_in  = 1'b0;
               if (req_tuser == OP_ALLOC) begin
                  row_in   = ptr_row;
                  state_in = ST_SCAN;
               end else begin
                  row_in       = victim_slot[SLOT_W-1:BIT_W];
                  bit_in       = victim_slot[BIT_W-1:0];
                  victim_ok_in = victim_ext < 32'(POOL_SLOTS);
                  state_in     = ST_FREE;
               end
            end
         end
         ST_SCAN: begin
            if (hit.found) begin
               wr_en                = 1'b1;
               wr_data              = rd_word | (word_type'(1) << hit.index);
               row_valid_in[row_ff] = 1'b1;
               slot_in              = hit_ext[FIELD_W-1:0];
               ptr_in               = (ptr_sum >= 32'(POOL_SLOTS)) ? '0
                                                                   : ptr_sum[SLOT_W-1:0];
               state_in             = ST_RESP;
            end else if (visit_ff == visit_type'(ROWS)) begin
               fail_in  = 1'b1;
               state_in = ST_RESP;
            end else begin
               row_in   = row_next;
               visit_in = visit_ff + 1'b1;
            end
         end
         ST_FREE: begin
            wr_en   = victim_ok_ff;
            wr_data = rd_word & ~(word_type'(1) << bit_ff);
            if (victim_ok_ff) begin
               row_valid_in[row_ff] = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_fail_in  = fail_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      bit_ff       <= bit_in;
      visit_ff     <= visit_in;
      victim_ok_ff <= victim_ok_in;
      slot_ff      <= slot_in;
      fail_ff      <= fail_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fail_ff  <= rsp_fail_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - FIELD_W){1'b0}}, rsp_slot_ff};
   assign rsp_tuser  = rsp_fail_ff;

   a_ptr_in_pool: assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) < 32'(POOL_SLOTS))
      else $error("search pointer outside pool");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("failed allocate carries a nonzero slot");

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(visit_ff) <= 32'(ROWS)))
      else $error("scan ran past one full lap");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && (state_ff == ST_IDLE)))
      else $error("block not idle after reset");

endmodule

@@ bench/next_fit_slot_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit slot allocator testbench
// Sends allocate and free transfers in bursts with random gaps. A local
// occupancy map and search pointer predict each grant, and every response is
// checked against the oldest prediction while the response side stalls on a
// pattern of its own. Covers the empty pool, a completely full pool, pointer
// wrap, frees of idle slots, and long random runs on a crowded pool.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_test import nfsa_pkg::*; ();

   typedef struct {
      logic [FIELD_W-1:0] slot;
      logic               failed;
   } grant_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   bit          occupancy [POOL_SLOTS];
   int          next_probe    = 0;
   int          used_count    = 0;
   grant_type   grant_expect [$];
   int          error_count   = 0;
   int          alloc_count   = 0;
   int          free_count    = 0;
   int          full_count    = 0;
   int          checked_count = 0;
   int          burst_left    = 0;
   int          stall_left    = 0;
   int          mode_cycles   = 0;
   bit          stall_mode    = 1'b1;

   next_fit_slot_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic grant_type predict_grant(input logic op, input logic [FIELD_W-1:0] slot);
      grant_type g;
      int        probe;
      g.slot   = '0;
      g.failed = 1'b0;
      if (op == OP_FREE) begin
         if (int'(slot) < POOL_SLOTS) begin
            if (occupancy[slot]) used_count--;
            occupancy[slot] = 1'b0;
         end
         return g;
      end
      probe = next_probe;
      for (int tried = 0; tried < POOL_SLOTS; tried++) begin
         if (!occupancy[probe]) begin
            occupancy[probe] = 1'b1;
            used_count++;
            next_probe = (probe + 1) % POOL_SLOTS;
            g.slot     = probe[FIELD_W-1:0];
            return g;
         end
         probe = (probe + 1) % POOL_SLOTS;
      end
      g.failed = 1'b1;
      return g;
   endfunction

   task automatic report_mismatch(input string field, input int expected, input int got);
      $display("mismatch: %s expected %0d got %0d at %0t", field, expected, got, $realtime);
      error_count++;
   endtask

   task automatic send_item(input logic op, input logic [FIELD_W-1:0] slot);
      grant_type g;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, slot};
      do @(posedge clock); while (!req_tready);
      g = predict_grant(op, slot);
      grant_expect.push_back(g);
      if (op == OP_FREE) free_count++;
      else alloc_count++;
      if (g.failed) full_count++;
   endtask

   always @(posedge clock) begin : response_check
      grant_type g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grant_expect.size() == 0) begin
               report_mismatch("unexpected response, granted_slot", 0, int'(rsp_tdata));
            end else begin
               g = grant_expect.pop_front();
               checked_count++;
               if (rsp_tdata !== {4'b0000, g.slot})
                  report_mismatch("granted_slot", int'(g.slot), int'(rsp_tdata));
               if (rsp_tuser !== g.failed)
                  report_mismatch("alloc_failed", int'(g.failed), int'(rsp_tuser));
            end
         end
         mode_cycles++;
         if (mode_cycles == 300) begin
            mode_cycles = 0;
            stall_mode  = ~stall_mode;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_mode && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_directed();
      send_item(OP_ALLOC, 12'hFFF);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_FREE,  12'hFFF);
      send_item(OP_FREE,  12'h000);
      send_item(OP_ALLOC, 12'h555);
      send_item(OP_FREE,  12'h001);
      send_item(OP_FREE,  12'h001);
      send_item(OP_ALLOC, 12'hAAA);
      send_item(OP_FREE,  12'hAAA);
      send_item(OP_FREE,  12'h555);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_FREE,  12'h002);
   endtask

   task automatic test_pool_full();
      while (used_count < POOL_SLOTS)
         send_item(OP_ALLOC, FIELD_W'($urandom_range(0, 4095)));
      send_item(OP_ALLOC, 12'hFFF);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_FREE,  12'hFFF);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_FREE,  12'h000);
      send_item(OP_FREE,  12'hFFF);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_FREE,  12'h800);
      send_item(OP_ALLOC, 12'h000);
      send_item(OP_ALLOC, 12'h000);
   endtask

   task automatic test_random(input int count, input int alloc_weight);
      logic [FIELD_W-1:0] slot;
      for (int i = 0; i < count; i++) begin
         slot = FIELD_W'($urandom_range(0, 4095));
         if ($urandom_range(0, 99) < alloc_weight) begin
            send_item(OP_ALLOC, slot);
         end else begin
            if ($urandom_range(0, 1) == 1)
               slot = FIELD_W'((next_probe + POOL_SLOTS - 1 - int'($urandom_range(0, 255)))
                               % POOL_SLOTS);
            send_item(OP_FREE, slot);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pool_full();
      test_random(400, 35);
      test_random(400, 65);
      test_random(400, 50);
      req_tvalid <= 1'b0;
      while (grant_expect.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("tb: sent %0d allocate and %0d free transfers, %0d allocates on a full pool",
               alloc_count, free_count, full_count);
      $display("tb: checked %0d responses, %0d mismatches", checked_count, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(25_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
